FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMP_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

FILE: rtl/core/ntc_pkg.sv
package ntc_pkg;

    localparam int ADC_W          = 12;
    localparam int CFG_W          = 20;
    localparam int RES_W          = 32;
    localparam int TEMP_W         = 7;
    localparam int TABLE_STEPS    = 100;
    localparam int ROM_ENTRIES    = TABLE_STEPS + 1;
    localparam int DIV_BITS       = 4;
    localparam int DIV_STAGES     = RES_W / DIV_BITS;
    localparam int GROUP_SIZE     = 10;
    localparam int GROUPS         = (TABLE_STEPS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GCNT_W         = $clog2(GROUP_SIZE + 1);

    localparam logic [ADC_W:0]   FULL_SCALE      = 13'd4096;
    localparam logic [RES_W-1:0] ZERO_COUNT_RES  = 32'd10000000;
    localparam logic [CFG_W-1:0] FIXED_RES_RESET = 20'd100000;

    localparam logic [RES_W-1:0] ROM [ROM_ENTRIES] = '{
        32'd317700, 32'd302500, 32'd288200, 32'd274500, 32'd261600,
        32'd249400, 32'd237700, 32'd226700, 32'd216200, 32'd206300,
        32'd196800, 32'd187800, 32'd179300, 32'd171200, 32'd163500,
        32'd156200, 32'd149300, 32'd142600, 32'd136300, 32'd130400,
        32'd124700, 32'd119200, 32'd114100, 32'd109100, 32'd104500,
        32'd100000, 32'd95750,  32'd91700,  32'd87840,  32'd84160,
        32'd80640,  32'd77300,  32'd74100,  32'd71060,  32'd68150,
        32'd65380,  32'd62730,  32'd60200,  32'd57780,  32'd55480,
        32'd53270,  32'd51170,  32'd49150,  32'd47230,  32'd45390,
        32'd43630,  32'd41950,  32'd40340,  32'd38800,  32'd37330,
        32'd35920,  32'd34570,  32'd33280,  32'd32040,  32'd30860,
        32'd29720,  32'd28630,  32'd27590,  32'd26590,  32'd25640,
        32'd24720,  32'd23840,  32'd22990,  32'd22180,  32'd21410,
        32'd20660,  32'd19940,  32'd19260,  32'd18600,  32'd17960,
        32'd17350,  32'd16770,  32'd16210,  32'd15670,  32'd15150,
        32'd14650,  32'd14170,  32'd13710,  32'd13260,  32'd12840,
        32'd12430,  32'd12030,  32'd11650,  32'd11280,  32'd10930,
        32'd10590,  32'd10270,  32'd9955,   32'd9654,   32'd9363,
        32'd9083,   32'd8812,   32'd8550,   32'd8297,   32'd8052,
        32'd7816,   32'd7587,   32'd7366,   32'd7152,   32'd6945,
        32'd6744
    };

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic [ADC_W-1:0] count;
        logic [RES_W-1:0] num;
    } prod_t;

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic [RES_W-1:0] quot;
    } quot_t;

    typedef struct packed {
        logic              valid;
        logic [TEMP_W-1:0] temp;
        logic [RES_W-1:0]  res;
    } result_t;

endpackage

FILE: rtl/core/ntc_mul.sv
module ntc_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        item_valid,
    input  logic [ntc_pkg::ADC_W-1:0]   adc_count,
    input  logic [ntc_pkg::CFG_W-1:0]   fixed_res,
    output ntc_pkg::prod_t              prod
);

    ntc_pkg::prod_t                            prod_reg;
    ntc_pkg::prod_t                            prod_next;
    logic [ntc_pkg::ADC_W:0]                   span;
    logic [ntc_pkg::CFG_W+ntc_pkg::ADC_W:0]    full_prod;

    always_comb
    begin
        span            = ntc_pkg::FULL_SCALE - {1'b0, adc_count};
        full_prod       = fixed_res * span;
        prod_next.valid = item_valid;
        prod_next.zero  = (adc_count == '0);
        prod_next.count = adc_count;
        prod_next.num   = full_prod[ntc_pkg::RES_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
        end
        else if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/core/ntc_div.sv
module ntc_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  ntc_pkg::prod_t  prod,
    output ntc_pkg::quot_t  quot
);

    typedef struct packed {
        logic                      valid;
        logic                      zero;
        logic [ntc_pkg::ADC_W-1:0] count;
        logic [ntc_pkg::ADC_W-1:0] rem;
        logic [ntc_pkg::RES_W-1:0] num;
    } div_stage_t;

    function automatic div_stage_t div_steps(input div_stage_t d);
        div_stage_t              r;
        logic [ntc_pkg::ADC_W:0] trial;
        r = d;
        for (int k = 0; k < ntc_pkg::DIV_BITS; k++)
        begin
            trial = {r.rem, r.num[ntc_pkg::RES_W-1]};
            if (trial >= {1'b0, r.count})
            begin
                trial = trial - {1'b0, r.count};
                r.rem = trial[ntc_pkg::ADC_W-1:0];
                r.num = {r.num[ntc_pkg::RES_W-2:0], 1'b1};
            end
            else
            begin
                r.rem = trial[ntc_pkg::ADC_W-1:0];
                r.num = {r.num[ntc_pkg::RES_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    div_stage_t stage_reg  [ntc_pkg::DIV_STAGES];
    div_stage_t stage_next [ntc_pkg::DIV_STAGES];
    div_stage_t first_in;

    always_comb
    begin
        first_in.valid = prod.valid;
        first_in.zero  = prod.zero;
        first_in.count = prod.count;
        first_in.rem   = '0;
        first_in.num   = prod.num;
    end

    for (genvar s = 0; s < ntc_pkg::DIV_STAGES; s++)
    begin : g_stage
        if (s == 0)
        begin : g_first
            assign stage_next[s] = div_steps(first_in);
        end
        else
        begin : g_rest
            assign stage_next[s] = div_steps(stage_reg[s-1]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_reg[s] <= '0;
            end
            else if (en)
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    assign quot.valid = stage_reg[ntc_pkg::DIV_STAGES-1].valid;
    assign quot.zero  = stage_reg[ntc_pkg::DIV_STAGES-1].zero;
    assign quot.quot  = stage_reg[ntc_pkg::DIV_STAGES-1].num;

endmodule

FILE: rtl/core/ntc_lut.sv
module ntc_lut (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  ntc_pkg::quot_t   quot,
    output ntc_pkg::result_t result
);

    localparam int PAD_W = ntc_pkg::GROUPS * ntc_pkg::GROUP_SIZE;

    logic                          cmp_valid_reg;
    logic [ntc_pkg::RES_W-1:0]     cmp_res_reg;
    logic [PAD_W-1:0]              cmp_gt_reg;
    logic [ntc_pkg::RES_W-1:0]     cmp_res_next;
    logic [PAD_W-1:0]              cmp_gt_next;

    logic                          grp_valid_reg;
    logic [ntc_pkg::RES_W-1:0]     grp_res_reg;
    logic [ntc_pkg::GCNT_W-1:0]    grp_cnt_reg  [ntc_pkg::GROUPS];
    logic [ntc_pkg::GCNT_W-1:0]    grp_cnt_next [ntc_pkg::GROUPS];

    logic [ntc_pkg::TEMP_W-1:0]    temp_sum;

    always_comb
    begin
        cmp_res_next = quot.zero ? ntc_pkg::ZERO_COUNT_RES : quot.quot;
        cmp_gt_next  = '0;
        for (int j = 1; j <= ntc_pkg::TABLE_STEPS; j++)
        begin
            cmp_gt_next[j-1] = (ntc_pkg::ROM[j] > cmp_res_next);
        end
    end

    always_comb
    begin
        for (int g = 0; g < ntc_pkg::GROUPS; g++)
        begin
            grp_cnt_next[g] = '0;
            for (int b = 0; b < ntc_pkg::GROUP_SIZE; b++)
            begin
                grp_cnt_next[g] = grp_cnt_next[g]
                    + ntc_pkg::GCNT_W'(cmp_gt_reg[g*ntc_pkg::GROUP_SIZE+b]);
            end
        end
    end

    always_comb
    begin
        temp_sum = '0;
        for (int g = 0; g < ntc_pkg::GROUPS; g++)
        begin
            temp_sum = temp_sum + ntc_pkg::TEMP_W'(grp_cnt_reg[g]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg <= 1'b0;
            grp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            cmp_valid_reg <= quot.valid;
            grp_valid_reg <= cmp_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmp_res_reg <= cmp_res_next;
            cmp_gt_reg  <= cmp_gt_next;
            grp_res_reg <= cmp_res_reg;
            grp_cnt_reg <= grp_cnt_next;
        end
    end

    assign result.valid = grp_valid_reg;
    assign result.temp  = temp_sum;
    assign result.res   = grp_res_reg;

endmodule

FILE: rtl/core/ntc_adc_to_celsius_top.sv
// NTC divider reading to temperature converter.
// Input channel: in_valid / in_stall with adc_count, one 12-bit converter
// reading per item. Output channel: out_valid / out_stall with temperature_c
// (0..100 degrees) and resistance_tenth_ohm, one result item per input item.
// Configuration: cfg_valid / cfg_ready / cfg_data writes the series resistor
// value in tenths of an ohm; cfg_ready is always high. Write it only while
// no item is in flight.
// Pipeline: an accepted item passes through one multiply stage, eight
// divider stages of four quotient bits each, a table compare stage, a group
// count stage, then the output register.
// Throughput: one item per cycle while in_stall is low, set by the fully
// pipelined divider and the parallel compares against the 101-entry resistance table.
// Reset clears all valid bits and loads the series resistor with 10 kOhm.
// When the receiver stalls, the result holds and one more result is caught
// in a skid register; in_stall then rises and the whole pipeline holds
// until the skid register drains. No item is lost or repeated.
`include "assert_macros.svh"

module ntc_adc_to_celsius_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [ntc_pkg::ADC_W-1:0]    adc_count,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ntc_pkg::TEMP_W-1:0]   temperature_c,
    output logic [ntc_pkg::RES_W-1:0]    resistance_tenth_ohm,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ntc_pkg::CFG_W-1:0]    cfg_data
);

    logic [ntc_pkg::CFG_W-1:0]  fixed_res_reg;
    logic                       en;
    ntc_pkg::prod_t             prod;
    ntc_pkg::quot_t             quot;
    ntc_pkg::result_t           pipe_out;

    logic                       out_valid_reg;
    logic [ntc_pkg::TEMP_W-1:0] out_temp_reg;
    logic [ntc_pkg::RES_W-1:0]  out_res_reg;
    logic                       skid_valid_reg;
    logic [ntc_pkg::TEMP_W-1:0] skid_temp_reg;
    logic [ntc_pkg::RES_W-1:0]  skid_res_reg;
    logic                       out_take;

    assign cfg_ready = 1'b1;
    assign en        = !skid_valid_reg;
    assign in_stall  = skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_res_reg <= ntc_pkg::FIXED_RES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            fixed_res_reg <= cfg_data;
        end
    end

    ntc_mul u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .item_valid (in_valid),
        .adc_count  (adc_count),
        .fixed_res  (fixed_res_reg),
        .prod       (prod)
    );

    ntc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .prod  (prod),
        .quot  (quot)
    );

    ntc_lut u_lut (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .quot   (quot),
        .result (pipe_out)
    );

    // drain skid first; otherwise route the pipeline item to output or skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (pipe_out.valid)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_temp_reg <= skid_temp_reg;
                out_res_reg  <= skid_res_reg;
            end
        end
        else if (pipe_out.valid)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_temp_reg <= pipe_out.temp;
                skid_res_reg  <= pipe_out.res;
            end
            else
            begin
                out_temp_reg <= pipe_out.temp;
                out_res_reg  <= pipe_out.res;
            end
        end
    end

    assign out_valid            = out_valid_reg;
    assign temperature_c        = out_temp_reg;
    assign resistance_tenth_ohm = out_res_reg;

    `ASSERT_IMP(a_skid_needs_out, skid_valid_reg, out_valid_reg)
    `ASSERT_IMP_NEXT(a_skid_fill_on_stall, !skid_valid_reg && pipe_out.valid && out_valid_reg && out_stall, skid_valid_reg)
    `ASSERT_IMP(a_temp_range, out_valid_reg, out_temp_reg <= ntc_pkg::TEMP_W'(ntc_pkg::TABLE_STEPS))
    `ASSERT_IMP(a_clamp_cold, out_valid_reg && (out_res_reg > ntc_pkg::ROM[0]), out_temp_reg == '0)

endmodule
